[rtl/record_lexicographic_sorter_unit_macros.svh]
// Assertion macros for the record sorter checker.
// Used by rls_checker.sv only; no other dependencies.
`ifndef RECORD_LEXICOGRAPHIC_SORTER_UNIT_MACROS_SVH
`define RECORD_LEXICOGRAPHIC_SORTER_UNIT_MACROS_SVH

// same-cycle implication
`define RLS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rls check failed");

// next-cycle implication
`define RLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rls check failed");

// delayed implication
`define RLS_ASSERT_TWO(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("rls check failed");

`endif

[rtl/rls_pkg.sv]
// Shared constants and types for the record sorter.
// No dependencies; compiled first.
package rls_pkg;

   localparam int NUM_SCORES      = 5;
   localparam int MAX_RECORDS_DEF = 64;
   localparam int SCORE_WIDTH_DEF = 16;

   // 9-comparator sorting network for five values, in dependency order
   localparam int NET_STAGES = 9;
   localparam int NET_HI [NET_STAGES] = '{0, 3, 2, 2, 1, 0, 0, 1, 1};
   localparam int NET_LO [NET_STAGES] = '{1, 4, 4, 3, 4, 3, 2, 3, 2};

   // broadcast control for the cell chain
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

endpackage

[rtl/rls_req_if.sv]
// Request channel: one record beat of five scores plus end-of-set flag.
// Depends on rls_pkg for the default score width.
interface rls_req_if #(parameter int SCORE_WIDTH = rls_pkg::SCORE_WIDTH_DEF);
   logic                   valid;
   logic                   ready;
   logic [SCORE_WIDTH-1:0] score_0;
   logic [SCORE_WIDTH-1:0] score_1;
   logic [SCORE_WIDTH-1:0] score_2;
   logic [SCORE_WIDTH-1:0] score_3;
   logic [SCORE_WIDTH-1:0] score_4;
   logic                   last_in;

   modport source (output valid, score_0, score_1, score_2, score_3, score_4, last_in,
                   input ready);
   modport sink   (input valid, score_0, score_1, score_2, score_3, score_4, last_in,
                   output ready);
endinterface

[rtl/rls_rsp_if.sv]
// Response channel: one sorted record beat plus end-of-output flag.
// Depends on rls_pkg for the default score width.
interface rls_rsp_if #(parameter int SCORE_WIDTH = rls_pkg::SCORE_WIDTH_DEF);
   logic                   valid;
   logic                   ready;
   logic [SCORE_WIDTH-1:0] top_0;
   logic [SCORE_WIDTH-1:0] top_1;
   logic [SCORE_WIDTH-1:0] top_2;
   logic [SCORE_WIDTH-1:0] top_3;
   logic [SCORE_WIDTH-1:0] top_4;
   logic                   last_out;

   modport source (output valid, top_0, top_1, top_2, top_3, top_4, last_out,
                   input ready);
   modport sink   (input valid, top_0, top_1, top_2, top_3, top_4, last_out,
                   output ready);
endinterface

[rtl/rls_presort.sv]
// Input stage: sorts the five scores of a record in descending order, registered.
// Depends on rls_pkg for the sorting network tables.
module rls_presort #(
   parameter int SCORE_WIDTH = rls_pkg::SCORE_WIDTH_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         load,
   input  logic [rls_pkg::NUM_SCORES-1:0][SCORE_WIDTH-1:0] scores,
   input  logic                                         last_in,
   output logic                                         valid,
   output logic                                         last,
   output logic [rls_pkg::NUM_SCORES*SCORE_WIDTH-1:0]   rec
);
   import rls_pkg::*;

   logic [SCORE_WIDTH-1:0]            net [NUM_SCORES];
   logic [NUM_SCORES*SCORE_WIDTH-1:0] rec_in;
   logic [NUM_SCORES*SCORE_WIDTH-1:0] rec_ff;
   logic                              valid_ff;
   logic                              last_ff;

   // largest value ends at index 0
   always_comb begin
      logic [SCORE_WIDTH-1:0] tmp;
      tmp = '0;
      for (int i = 0; i < NUM_SCORES; i++) begin
         net[i] = scores[i];
      end
      for (int s = 0; s < NET_STAGES; s++) begin
         if (net[NET_HI[s]] < net[NET_LO[s]]) begin
            tmp             = net[NET_HI[s]];
            net[NET_HI[s]]  = net[NET_LO[s]];
            net[NET_LO[s]]  = tmp;
         end
      end
      // pack with the largest score in the top bits so a plain compare is lexicographic
      for (int i = 0; i < NUM_SCORES; i++) begin
         rec_in[(NUM_SCORES-i)*SCORE_WIDTH-1 -: SCORE_WIDTH] = net[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= load;
      end
      if (load) begin
         rec_ff  <= rec_in;
         last_ff <= last_in;
      end
   end

   assign valid = valid_ff;
   assign last  = last_ff;
   assign rec   = rec_ff;

endmodule

[rtl/rls_cell.sv]
// One cell of the insertion chain: holds one sorted record and its valid flag.
// Depends on rls_pkg for the chain control struct.
module rls_cell #(
   parameter int SCORE_WIDTH = rls_pkg::SCORE_WIDTH_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  rls_pkg::cell_ctrl_type                     ctrl,
   input  logic [rls_pkg::NUM_SCORES*SCORE_WIDTH-1:0] new_rec,
   input  logic                                       prev_gt,
   input  logic                                       prev_valid,
   input  logic [rls_pkg::NUM_SCORES*SCORE_WIDTH-1:0] prev_rec,
   input  logic                                       next_valid,
   input  logic [rls_pkg::NUM_SCORES*SCORE_WIDTH-1:0] next_rec,
   output logic                                       gt,
   output logic                                       valid,
   output logic [rls_pkg::NUM_SCORES*SCORE_WIDTH-1:0] rec
);
   import rls_pkg::*;

   logic [NUM_SCORES*SCORE_WIDTH-1:0] rec_ff;
   logic [NUM_SCORES*SCORE_WIDTH-1:0] rec_in;
   logic                              valid_ff;
   logic                              valid_in;

   // an empty cell loses to anything; equal records keep the earlier one ahead
   assign gt = !valid_ff || (new_rec > rec_ff);

   always_comb begin
      rec_in   = rec_ff;
      valid_in = valid_ff;
      if (ctrl.shift) begin
         rec_in   = next_rec;
         valid_in = next_valid;
      end else if (ctrl.insert) begin
         if (prev_gt) begin
            // insertion point is upstream: take the neighbor's record
            rec_in   = prev_rec;
            valid_in = prev_valid;
         end else if (gt) begin
            rec_in   = new_rec;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rec_ff <= rec_in;
   end

   assign valid = valid_ff;
   assign rec   = rec_ff;

endmodule

[rtl/record_lexicographic_sorter_unit.sv]
// Record sorter: loads one record per cycle, while ready, into a chain of MAX_RECORDS
// insertion cells. A set's last record passes the presort register, then state_ff
// enters unload; results leave one per cycle from the chain head while rsp_chan is
// ready. No record is accepted while a set unloads, set by the single shifting chain.
// Synchronous reset empties the chain and the count; stored scores are not cleared.
module record_lexicographic_sorter_unit #(
   parameter int MAX_RECORDS = rls_pkg::MAX_RECORDS_DEF,
   parameter int SCORE_WIDTH = rls_pkg::SCORE_WIDTH_DEF
) (
   input logic      clock,
   input logic      reset,
   rls_req_if.sink   req_chan,
   rls_rsp_if.source rsp_chan
);
   import rls_pkg::*;

   localparam int REC_W = NUM_SCORES * SCORE_WIDTH;
   localparam int CNT_W = $clog2(MAX_RECORDS + 1);

   localparam logic ST_LOAD   = 1'b0;
   localparam logic ST_UNLOAD = 1'b1;

   logic             state_ff;
   logic             state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic                                  req_acc;
   logic                                  rsp_acc;
   logic                                  pre_valid;
   logic                                  pre_last;
   logic [REC_W-1:0]                      pre_rec;
   logic [NUM_SCORES-1:0][SCORE_WIDTH-1:0] req_scores;
   cell_ctrl_type                         ctrl;

   logic             cell_gt    [MAX_RECORDS];
   logic             cell_valid [MAX_RECORDS];
   logic [REC_W-1:0] cell_rec   [MAX_RECORDS];

   assign req_chan.ready = (state_ff == ST_LOAD) && !(pre_valid && pre_last);
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = (state_ff == ST_UNLOAD);
   assign rsp_acc        = rsp_chan.valid && rsp_chan.ready;

   assign req_scores[0] = req_chan.score_0;
   assign req_scores[1] = req_chan.score_1;
   assign req_scores[2] = req_chan.score_2;
   assign req_scores[3] = req_chan.score_3;
   assign req_scores[4] = req_chan.score_4;

   rls_presort #(.SCORE_WIDTH(SCORE_WIDTH)) u_presort (
      .clock   (clock),
      .reset   (reset),
      .load    (req_acc),
      .scores  (req_scores),
      .last_in (req_chan.last_in),
      .valid   (pre_valid),
      .last    (pre_last),
      .rec     (pre_rec)
   );

   // drop the record when the chain is full
   assign ctrl.insert = pre_valid && (count_ff != CNT_W'(MAX_RECORDS));
   assign ctrl.shift  = rsp_acc;

   for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
      logic             p_gt;
      logic             p_valid;
      logic [REC_W-1:0] p_rec;
      logic             n_valid;
      logic [REC_W-1:0] n_rec;

      if (i == 0) begin : g_head
         assign p_gt    = 1'b0;
         assign p_valid = 1'b0;
         assign p_rec   = '0;
      end else begin : g_body
         assign p_gt    = cell_gt[i-1];
         assign p_valid = cell_valid[i-1];
         assign p_rec   = cell_rec[i-1];
      end

      if (i == MAX_RECORDS - 1) begin : g_tail
         assign n_valid = 1'b0;
         assign n_rec   = '0;
      end else begin : g_mid
         assign n_valid = cell_valid[i+1];
         assign n_rec   = cell_rec[i+1];
      end

      rls_cell #(.SCORE_WIDTH(SCORE_WIDTH)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_rec    (pre_rec),
         .prev_gt    (p_gt),
         .prev_valid (p_valid),
         .prev_rec   (p_rec),
         .next_valid (n_valid),
         .next_rec   (n_rec),
         .gt         (cell_gt[i]),
         .valid      (cell_valid[i]),
         .rec        (cell_rec[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (ctrl.insert) begin
               count_in = count_ff + CNT_W'(1);
            end
            if (pre_valid && pre_last) begin
               state_in = ST_UNLOAD;
            end
         end
         ST_UNLOAD: begin
            if (rsp_acc) begin
               count_in = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   assign rsp_chan.top_0    = cell_rec[0][REC_W-1 -: SCORE_WIDTH];
   assign rsp_chan.top_1    = cell_rec[0][REC_W-SCORE_WIDTH-1 -: SCORE_WIDTH];
   assign rsp_chan.top_2    = cell_rec[0][REC_W-2*SCORE_WIDTH-1 -: SCORE_WIDTH];
   assign rsp_chan.top_3    = cell_rec[0][REC_W-3*SCORE_WIDTH-1 -: SCORE_WIDTH];
   assign rsp_chan.top_4    = cell_rec[0][SCORE_WIDTH-1:0];
   assign rsp_chan.last_out = (count_ff == CNT_W'(1));

endmodule

[rtl/rls_checker.sv]
// Port-level checks for the record sorter, bound to the top level.
// Depends on record_lexicographic_sorter_unit_macros.svh.
`include "record_lexicographic_sorter_unit_macros.svh"

module rls_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_last_in,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last_out
);
   logic req_beat;
   logic rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // hold a result until it is taken
   `RLS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // no input beat while a set drains
   `RLS_ASSERT_NOW(a_no_overlap, clock, reset, req_beat, !rsp_valid)
   // end of a set starts the drain once it has passed the presort and state registers
   `RLS_ASSERT_TWO(a_drain_start, clock, reset, req_beat && req_last_in, rsp_valid)
   // final result beat closes the drain
   `RLS_ASSERT_NEXT(a_drain_end, clock, reset, rsp_beat && rsp_last_out, !rsp_valid)

endmodule

bind record_lexicographic_sorter_unit rls_checker u_rls_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_last_in  (req_chan.last_in),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_last_out (rsp_chan.last_out)
);

[sim/tb_record_lexicographic_sorter_unit.sv]
// Self-checking testbench for record_lexicographic_sorter_unit: record sets in, sorted rows out.
// Needs rls_pkg, rls_req_if and rls_rsp_if from the RTL; the expected rows come from
// a behavioral sort kept in this file.
module tb_record_lexicographic_sorter_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW             = rls_pkg::SCORE_WIDTH_DEF;
   localparam int CAP            = rls_pkg::MAX_RECORDS_DEF;
   localparam int NS             = rls_pkg::NUM_SCORES;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int IDLE_PERCENT   = 24;

   typedef logic [SW-1:0]            score_type;
   typedef logic [NS-1:0][SW-1:0]    scores_type;
   // top_0 sits in the most significant slice, so a plain compare is lexicographic
   typedef logic [NS*SW-1:0]         tuple_type;
   typedef struct packed {
      tuple_type tuple;
      logic      last;
   } row_type;

   typedef enum {SPREAD_FULL, SPREAD_NARROW, SPREAD_EDGE} spread_type;

   logic clock;
   logic reset;

   rls_req_if #(.SCORE_WIDTH(SW)) req_chan ();
   rls_rsp_if #(.SCORE_WIDTH(SW)) rsp_chan ();

   record_lexicographic_sorter_unit #(
      .MAX_RECORDS(CAP),
      .SCORE_WIDTH(SW)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   tuple_type set_store[$];
   row_type   pending_rows[$];
   int        error_count;
   int        records_sent;
   int        rows_checked;
   int        sets_closed;
   int        dropped_records;
   int        quiet_cycles;
   bit        steady;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      error_count++;
   endtask

   function automatic scores_type rec(input score_type a, input score_type b,
                                      input score_type c, input score_type d,
                                      input score_type e);
      scores_type s;
      s[0] = a;
      s[1] = b;
      s[2] = c;
      s[3] = d;
      s[4] = e;
      return s;
   endfunction

   // Sort the record's scores, file it in the current set, release the set on last.
   function automatic void take_record(input scores_type s, input bit last);
      scores_type v;
      score_type  x;
      tuple_type  t;
      row_type    r;
      int         j;
      int         n;
      v = s;
      for (int i = 1; i < NS; i++) begin
         x = v[i];
         j = i;
         while (j > 0 && v[j-1] < x) begin
            v[j] = v[j-1];
            j--;
         end
         v[j] = x;
      end
      for (int i = 0; i < NS; i++) t[(NS-1-i)*SW +: SW] = v[i];
      if (set_store.size() < CAP) begin
         // strict compare keeps earlier equal tuples ahead
         j = set_store.size();
         while (j > 0 && t > set_store[j-1]) j--;
         set_store.insert(j, t);
      end else begin
         dropped_records++;
      end
      if (last) begin
         n = set_store.size();
         for (int k = 0; k < n; k++) begin
            r.tuple = set_store[k];
            r.last  = (k == n - 1);
            pending_rows.insert(pending_rows.size(), r);
         end
         set_store.delete();
         sets_closed++;
      end
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_record(input scores_type s, input bit last);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid   = 1'b1;
      req_chan.score_0 = s[0];
      req_chan.score_1 = s[1];
      req_chan.score_2 = s[2];
      req_chan.score_3 = s[3];
      req_chan.score_4 = s[4];
      req_chan.last_in = last;
      do @(posedge clock); while (!req_chan.ready);
      take_record(s, last);
      records_sent++;
      @(negedge clock);
   endtask

   // Hold the sender until every pending row has come back.
   task automatic wait_drained();
      req_chan.valid = 1'b0;
      while (pending_rows.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic score_type pick_score(input spread_type how);
      score_type edges[5];
      edges[0] = '0;
      edges[1] = '1;
      edges[2] = score_type'(1);
      edges[3] = '1 - score_type'(1);
      edges[4] = score_type'(1) << (SW - 1);
      case (how)
         SPREAD_NARROW: return score_type'($urandom_range(3));
         SPREAD_EDGE:   return edges[$urandom_range(4)];
         default:       return score_type'($urandom);
      endcase
   endfunction

   function automatic scores_type draw_record();
      scores_type s;
      spread_type how;
      int         roll;
      roll = $urandom_range(99);
      how  = (roll < 50) ? SPREAD_FULL : (roll < 85) ? SPREAD_NARROW : SPREAD_EDGE;
      for (int i = 0; i < NS; i++) s[i] = pick_score(how);
      return s;
   endfunction

   task automatic test_lone_records();
      send_record(rec('0, '0, '0, '0, '0), 1'b1);
      send_record(rec('1, '1, '1, '1, '1), 1'b1);
      send_record(rec(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555), 1'b1);
   endtask

   // Tuples that agree on a prefix and differ further down, plus a permuted duplicate.
   task automatic test_tuple_order();
      send_record(rec(16'd5, 16'd4, 16'd3, 16'd2, 16'd1), 1'b0);
      send_record(rec(16'd1, 16'd2, 16'd3, 16'd4, 16'd5), 1'b0);
      send_record(rec(16'd5, 16'd4, 16'd3, 16'd2, 16'd0), 1'b0);
      send_record(rec(16'd3, 16'd1, 16'd5, 16'd3, 16'd4), 1'b0);
      send_record(rec(16'd0, 16'd0, 16'd6, 16'd0, 16'd0), 1'b0);
      send_record(rec('1, '0, '1, '0, '1), 1'b0);
      send_record(rec('0, '0, '0, '0, '0), 1'b0);
      send_record(rec(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA), 1'b0);
      send_record(rec('1, '1, '1, '1, '1), 1'b1);
   endtask

   // Overfill the store with back-to-back beats; the extra records are dropped.
   task automatic test_store_full();
      steady = 1'b1;
      for (int k = 0; k < CAP + 2; k++) send_record(draw_record(), k == CAP + 1);
      wait_drained();
      steady = 1'b0;
   endtask

   task automatic test_random_sets(input int budget);
      int sent;
      int size;
      sent = 0;
      while (sent < budget) begin
         size = ($urandom_range(5) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
         for (int k = 0; k < size; k++) send_record(draw_record(), k == size - 1);
         sent += size;
         if ($urandom_range(7) == 0) wait_drained();
      end
   endtask

   always @(negedge clock) begin
      rsp_chan.ready = steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      row_type   seen;
      row_type   want;
      score_type got_f;
      score_type want_f;
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.tuple = {rsp_chan.top_0, rsp_chan.top_1, rsp_chan.top_2,
                          rsp_chan.top_3, rsp_chan.top_4};
            seen.last  = rsp_chan.last_out;
            if (pending_rows.size() == 0) begin
               report_mismatch($sformatf("row %h with nothing pending", seen.tuple));
            end else begin
               want = pending_rows.pop_front();
               rows_checked++;
               for (int i = 0; i < NS; i++) begin
                  got_f  = seen.tuple[(NS-1-i)*SW +: SW];
                  want_f = want.tuple[(NS-1-i)*SW +: SW];
                  if (got_f !== want_f)
                     report_mismatch($sformatf("top_%0d got %h want %h", i, got_f, want_f));
               end
               if (seen.last !== want.last)
                  report_mismatch($sformatf("last_out got %b want %b", seen.last, want.last));
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d rows pending",
                     quiet_cycles, pending_rows.size());
            $display("tb_record_lexicographic_sorter_unit: errors");
            $finish;
         end
      end
   end

   initial begin
      reset            = 1'b1;
      steady           = 1'b0;
      error_count      = 0;
      records_sent     = 0;
      rows_checked     = 0;
      sets_closed      = 0;
      dropped_records  = 0;
      quiet_cycles     = 0;
      req_chan.valid   = 1'b0;
      req_chan.score_0 = '0;
      req_chan.score_1 = '0;
      req_chan.score_2 = '0;
      req_chan.score_3 = '0;
      req_chan.score_4 = '0;
      req_chan.last_in = 1'b0;
      rsp_chan.ready   = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_lone_records();
      test_tuple_order();
      wait_drained();
      test_store_full();
      test_random_sets(30);
      wait_drained();

      $display("covered %0d records in %0d sets, %0d dropped on a full store",
               records_sent, sets_closed, dropped_records);
      $display("checked %0d sorted rows, %0d mismatches", rows_checked, error_count);
      if (error_count == 0)
         $display("tb_record_lexicographic_sorter_unit: clean");
      else
         $display("tb_record_lexicographic_sorter_unit: errors");
      $finish;
   end

endmodule
